### design/ftip_pkg.sv
// Shared constants and types for the flow table insert block.
package ftip_pkg;

  localparam int MAIN_DEPTH = 1024;
  localparam int ANC_DEPTH  = 256;
  localparam int MAX_PROBES = 4;
  localparam int MAIN_AW    = $clog2(MAIN_DEPTH);
  localparam int ANC_AW     = $clog2(ANC_DEPTH);
  localparam int KEY_W      = 104;
  localparam int CNT_W      = 31;
  localparam int PRB_W      = 3;
  localparam logic [CNT_W-1:0] COUNT_MAX = {CNT_W{1'b1}};

  localparam logic [1:0] OUT_MATCH   = 2'd0;
  localparam logic [1:0] OUT_CLAIM   = 2'd1;
  localparam logic [1:0] OUT_ANC     = 2'd2;
  localparam logic [1:0] OUT_PROMOTE = 2'd3;

  // Commands from controller to datapath.
  typedef struct packed {
    logic               clear;
    logic [MAIN_AW-1:0] clr_addr;
    logic               load;
    logic               main_rd;
    logic               eval;
    logic               anc_rd;
    logic               anc_upd;
    logic               promote;
    logic               finish;
    logic [1:0]         probe;
  } ftip_cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic hit;
    logic promo;
  } ftip_sts_t;

  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] a,
                                               input logic [CNT_W-1:0] b);
    logic [CNT_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[CNT_W] ? COUNT_MAX : s[CNT_W-1:0];
  endfunction

endpackage

### design/flow_table_insert_with_promotion_top.sv
// Top level of the flow table insert with promotion block.
// After reset the block clears its tables with in_stall high.
// One request at a time: each probe is a single-port read, then a compare and
// write. When no probe hits, the ancillary bucket is read and updated, then
// the flow may be promoted into the probed slot with the lowest count.
// A stalled result holds the block before the next request is taken.
module flow_table_insert_with_promotion_top import ftip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_proto,
  input  logic [15:0] in_increment,
  input  logic [9:0]  in_probe_index_0,
  input  logic [9:0]  in_probe_index_1,
  input  logic [9:0]  in_probe_index_2,
  input  logic [9:0]  in_probe_index_3,
  input  logic [7:0]  in_bucket_index,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [1:0]  out_outcome,
  output logic [9:0]  out_main_slot,
  output logic [7:0]  out_anc_slot,
  output logic [30:0] out_count_after,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_data
);

  logic [PRB_W-1:0] probes_r;
  ftip_cmd_t cmd;
  ftip_sts_t sts;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) probes_r <= PRB_W'(MAX_PROBES);
    else if (cfg_valid && cfg_ready) probes_r <= cfg_data;
  end

  ftip_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .probes(probes_r),
    .sts(sts), .cmd(cmd));

  ftip_dp u_dp (
    .clk(clk), .rst_n(rst_n),
    .in_src_addr(in_src_addr), .in_dst_addr(in_dst_addr),
    .in_src_port(in_src_port), .in_dst_port(in_dst_port),
    .in_proto(in_proto), .in_increment(in_increment),
    .in_probe_index_0(in_probe_index_0), .in_probe_index_1(in_probe_index_1),
    .in_probe_index_2(in_probe_index_2), .in_probe_index_3(in_probe_index_3),
    .in_bucket_index(in_bucket_index), .cmd(cmd), .out_stall(out_stall),
    .sts(sts), .out_valid(out_valid), .out_outcome(out_outcome),
    .out_main_slot(out_main_slot), .out_anc_slot(out_anc_slot),
    .out_count_after(out_count_after));

endmodule

### design/ftip_ram.sv
// Generic single-port RAM with registered read.
module ftip_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end

endmodule

### design/ftip_ctrl.sv
// Controller state machine sequencing the table clear after reset, probes, bucket update and promotion.
module ftip_ctrl import ftip_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic             out_valid,
  input  logic             out_stall,
  input  logic [PRB_W-1:0] probes,
  input  ftip_sts_t        sts,
  output ftip_cmd_t        cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_RD   = 3'd1;
  localparam logic [2:0] S_EVAL = 3'd2;
  localparam logic [2:0] S_ARD  = 3'd3;
  localparam logic [2:0] S_AUPD = 3'd4;
  localparam logic [2:0] S_PROM = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;
  localparam logic [2:0] S_CLR  = 3'd7;

  logic [2:0]         state_r, state_nxt;
  logic [1:0]         probe_r, probe_nxt;
  logic [MAIN_AW-1:0] clr_r, clr_nxt;
  logic [1:0]         last;
  logic               accept;

  always_comb begin
    if (probes == '0) last = 2'd0;
    else if (probes > PRB_W'(MAX_PROBES)) last = 2'(MAX_PROBES - 1);
    else last = 2'(probes - 1'b1);
  end

  assign in_stall = (state_r != S_IDLE);
  assign accept   = in_valid && !in_stall;

  always_comb begin
    state_nxt    = state_r;
    probe_nxt    = probe_r;
    clr_nxt      = clr_r;
    cmd          = '0;
    cmd.probe    = probe_r;
    cmd.clr_addr = clr_r;
    unique case (state_r)
      S_CLR: begin
        cmd.clear = 1'b1;
        clr_nxt   = clr_r + MAIN_AW'(1);
        if (clr_r == MAIN_AW'(MAIN_DEPTH - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (accept) begin
          cmd.load  = 1'b1;
          state_nxt = S_RD;
          probe_nxt = 2'd0;
        end
      end
      S_RD: begin
        cmd.main_rd = 1'b1;
        state_nxt   = S_EVAL;
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.hit) state_nxt = S_DONE;
        else if (probe_r == last) state_nxt = S_ARD;
        else begin
          probe_nxt = probe_r + 2'd1;
          state_nxt = S_RD;
        end
      end
      S_ARD: begin
        cmd.anc_rd = 1'b1;
        state_nxt  = S_AUPD;
      end
      S_AUPD: begin
        cmd.anc_upd = 1'b1;
        state_nxt   = S_PROM;
      end
      S_PROM: begin
        cmd.promote = sts.promo;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || !out_stall) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      probe_r <= '0;
      clr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      probe_r <= probe_nxt;
      clr_r   <= clr_nxt;
    end
  end

  a_probe_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> (probe_r <= last)) else $error("probe past limit");
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> (state_r == S_RD)) else $error("load not followed by read");
  a_promo_after: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_PROM) |-> ($past(state_r) == S_AUPD)) else $error("promote order");

endmodule

### design/ftip_dp.sv
// Datapath: request registers, table memories and result register.
module ftip_dp import ftip_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic [31:0]        in_src_addr,
  input  logic [31:0]        in_dst_addr,
  input  logic [15:0]        in_src_port,
  input  logic [15:0]        in_dst_port,
  input  logic [7:0]         in_proto,
  input  logic [15:0]        in_increment,
  input  logic [9:0]         in_probe_index_0,
  input  logic [9:0]         in_probe_index_1,
  input  logic [9:0]         in_probe_index_2,
  input  logic [9:0]         in_probe_index_3,
  input  logic [7:0]         in_bucket_index,
  input  ftip_cmd_t          cmd,
  input  logic               out_stall,
  output ftip_sts_t          sts,
  output logic               out_valid,
  output logic [1:0]         out_outcome,
  output logic [9:0]         out_main_slot,
  output logic [7:0]         out_anc_slot,
  output logic [30:0]        out_count_after
);

  logic [KEY_W-1:0]   key_r;
  logic [15:0]        inc_r;
  logic [MAIN_AW-1:0] idx_r [MAX_PROBES];
  logic [ANC_AW-1:0]  bkt_r;
  logic [MAIN_AW-1:0] slot_r, min_slot_r;
  logic [CNT_W-1:0]   min_cnt_r, bcnt_r;

  logic [MAIN_AW-1:0] cur_slot, m_addr;
  logic [KEY_W-1:0]   k_rd;
  logic [CNT_W:0]     vc_rd, vc_wd;
  logic [CNT_W-1:0]   c_rd, c_wd, new_cnt;
  logic [KEY_W-1:0]   k_wd;
  logic               k_we, c_we;
  logic [MAIN_AW+CNT_W-1:0] a_rd, a_wd, a_wr;
  logic [ANC_AW-1:0]  a_addr;
  logic [MAIN_AW-1:0] tag;
  logic [CNT_W-1:0]   acnt;
  logic               a_we, slot_empty, key_eq;

  logic [1:0]         oc_r;
  logic [MAIN_AW-1:0] os_r;
  logic [CNT_W-1:0]   ocnt_r;
  logic               ov_r;

  assign cur_slot   = idx_r[cmd.probe];
  assign c_rd       = vc_rd[CNT_W-1:0];
  assign slot_empty = !vc_rd[CNT_W];
  assign key_eq     = (k_rd == key_r);
  assign new_cnt    = sat_add(c_rd, CNT_W'(inc_r));
  assign m_addr     = cmd.clear ? cmd.clr_addr :
                      (cmd.promote ? min_slot_r : (cmd.eval ? slot_r : cur_slot));

  always_comb begin
    k_we = 1'b0;
    c_we = 1'b0;
    k_wd = key_r;
    c_wd = new_cnt;
    if (cmd.clear) begin
      c_we = 1'b1;
    end else if (cmd.eval && (slot_empty || key_eq)) begin
      k_we = 1'b1;
      c_we = 1'b1;
      c_wd = slot_empty ? CNT_W'(inc_r) : new_cnt;
    end else if (cmd.promote) begin
      k_we = 1'b1;
      c_we = 1'b1;
      c_wd = bcnt_r;
    end
  end

  assign vc_wd = cmd.clear ? '0 : {1'b1, c_wd};

  ftip_ram #(.WIDTH(KEY_W), .DEPTH(MAIN_DEPTH)) u_keys (
    .clk(clk), .we(k_we), .addr(m_addr), .wdata(k_wd), .rdata(k_rd));
  ftip_ram #(.WIDTH(CNT_W + 1), .DEPTH(MAIN_DEPTH)) u_cnts (
    .clk(clk), .we(c_we), .addr(m_addr), .wdata(vc_wd), .rdata(vc_rd));
  ftip_ram #(.WIDTH(MAIN_AW + CNT_W), .DEPTH(ANC_DEPTH)) u_anc (
    .clk(clk), .we(a_we), .addr(a_addr), .wdata(a_wr), .rdata(a_rd));

  assign tag    = a_rd[MAIN_AW+CNT_W-1:CNT_W];
  assign acnt   = a_rd[CNT_W-1:0];
  assign a_addr = cmd.clear ? cmd.clr_addr[ANC_AW-1:0] : bkt_r;
  assign a_we   = cmd.anc_upd || cmd.clear;
  assign a_wd   = (tag == slot_r) ? {slot_r, sat_add(acnt, CNT_W'(inc_r))}
                                  : {slot_r, CNT_W'(inc_r)};
  assign a_wr   = cmd.clear ? '0 : a_wd;

  assign sts.hit   = slot_empty || key_eq;
  assign sts.promo = (bcnt_r >= min_cnt_r);

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      key_r    <= {in_src_addr, in_dst_addr, in_src_port, in_dst_port, in_proto};
      inc_r    <= in_increment;
      idx_r[0] <= in_probe_index_0;
      idx_r[1] <= in_probe_index_1;
      idx_r[2] <= in_probe_index_2;
      idx_r[3] <= in_probe_index_3;
      bkt_r    <= in_bucket_index;
      min_slot_r <= in_probe_index_0;
      min_cnt_r  <= COUNT_MAX;
    end
    if (cmd.main_rd) slot_r <= cur_slot;
    if (cmd.eval && !(slot_empty || key_eq) && (c_rd < min_cnt_r)) begin
      min_cnt_r  <= c_rd;
      min_slot_r <= slot_r;
    end
    if (cmd.eval) begin
      oc_r   <= slot_empty ? OUT_CLAIM : OUT_MATCH;
      os_r   <= slot_r;
      ocnt_r <= c_wd;
    end
    if (cmd.anc_upd) begin
      bcnt_r <= a_wd[CNT_W-1:0];
      oc_r   <= OUT_ANC;
      os_r   <= slot_r;
      ocnt_r <= a_wd[CNT_W-1:0];
    end
    if (cmd.promote) begin
      oc_r   <= OUT_PROMOTE;
      os_r   <= min_slot_r;
      ocnt_r <= bcnt_r;
    end
    if (cmd.finish) begin
      out_outcome     <= oc_r;
      out_main_slot   <= os_r;
      out_anc_slot    <= bkt_r;
      out_count_after <= ocnt_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      if (cmd.finish) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
    end
  end

  assign out_valid = ov_r;

  a_eval_hit: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.eval && sts.hit) |-> (k_we && c_we)) else $error("hit without write");
  a_promo_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.promote |=> (oc_r == OUT_PROMOTE)) else $error("promote outcome lost");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (ov_r && out_stall) |-> !cmd.finish) else $error("result overwritten");

endmodule

### verif/ftip_checker.sv
// Checker for the flow table insert block: predicts each result and compares it.
`timescale 1ns / 1ps
module ftip_checker import ftip_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [31:0] in_src_addr,
  input  logic [31:0] in_dst_addr,
  input  logic [15:0] in_src_port,
  input  logic [15:0] in_dst_port,
  input  logic [7:0]  in_proto,
  input  logic [15:0] in_increment,
  input  logic [9:0]  in_probe_index_0,
  input  logic [9:0]  in_probe_index_1,
  input  logic [9:0]  in_probe_index_2,
  input  logic [9:0]  in_probe_index_3,
  input  logic [7:0]  in_bucket_index,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [1:0]  out_outcome,
  input  logic [9:0]  out_main_slot,
  input  logic [7:0]  out_anc_slot,
  input  logic [30:0] out_count_after,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [2:0]  cfg_data,
  output int          errors,
  output int          pending,
  output int          promotions,
  output int          bucket_only
);

  typedef struct packed {
    logic [1:0]       outcome;
    logic [MAIN_AW-1:0] slot;
    logic [ANC_AW-1:0]  bucket;
    logic [CNT_W-1:0]   count;
  } flow_update_t;

  flow_update_t       updates_q[$];
  logic [KEY_W-1:0]   slot_key[MAIN_DEPTH];
  bit                 slot_used[MAIN_DEPTH];
  logic [CNT_W-1:0]   slot_count[MAIN_DEPTH];
  logic [MAIN_AW-1:0] bkt_tag[ANC_DEPTH];
  logic [CNT_W-1:0]   bkt_count[ANC_DEPTH];
  logic [PRB_W-1:0]   probe_cfg;

  function automatic logic [CNT_W-1:0] clamp_add(logic [CNT_W-1:0] a, logic [CNT_W-1:0] b);
    logic [31:0] sum;
    sum = 32'(a) + 32'(b);
    if (sum > 32'(COUNT_MAX)) return COUNT_MAX;
    return sum[CNT_W-1:0];
  endfunction

  task automatic insert_flow(output flow_update_t u);
    logic [KEY_W-1:0]   key;
    logic [MAIN_AW-1:0] probes[4];
    logic [MAIN_AW-1:0] slot, min_slot;
    logic [CNT_W-1:0]   min_count;
    logic [ANC_AW-1:0]  b;
    int                 n;
    bit                 done;
    key = {in_src_addr, in_dst_addr, in_src_port, in_dst_port, in_proto};
    probes = '{in_probe_index_0, in_probe_index_1, in_probe_index_2, in_probe_index_3};
    b = in_bucket_index;
    n = (probe_cfg == 0) ? 1 : (probe_cfg > MAX_PROBES) ? MAX_PROBES : probe_cfg;
    min_slot = probes[0];
    min_count = COUNT_MAX;
    slot = '0;
    done = 0;
    u.bucket = b;
    for (int i = 0; i < n && !done; i++) begin
      slot = probes[i];
      if (!slot_used[slot] || slot_key[slot] == key) begin
        u.outcome = slot_used[slot] ? OUT_MATCH : OUT_CLAIM;
        slot_used[slot] = 1;
        slot_key[slot] = key;
        slot_count[slot] = clamp_add(slot_count[slot], CNT_W'(in_increment));
        u.slot = slot;
        u.count = slot_count[slot];
        done = 1;
      end else if (slot_count[slot] < min_count) begin
        min_count = slot_count[slot];
        min_slot = slot;
      end
    end
    if (!done) begin
      if (bkt_tag[b] == slot) begin
        bkt_count[b] = clamp_add(bkt_count[b], CNT_W'(in_increment));
      end else begin
        bkt_tag[b] = slot;
        bkt_count[b] = CNT_W'(in_increment);
      end
      u.outcome = OUT_ANC;
      u.slot = slot;
      u.count = bkt_count[b];
      if (bkt_count[b] >= min_count) begin
        slot_key[min_slot] = key;
        slot_used[min_slot] = 1;
        slot_count[min_slot] = bkt_count[b];
        u.outcome = OUT_PROMOTE;
        u.slot = min_slot;
      end
    end
  endtask

  always @(posedge clk) begin
    flow_update_t exp_u;
    if (!rst_n) begin
      updates_q.delete();
      for (int i = 0; i < MAIN_DEPTH; i++) begin
        slot_used[i] = 0;
        slot_count[i] = '0;
        slot_key[i] = '0;
      end
      for (int i = 0; i < ANC_DEPTH; i++) begin
        bkt_tag[i] = '0;
        bkt_count[i] = '0;
      end
      probe_cfg = 3'(MAX_PROBES);
      errors = 0;
      pending = 0;
      promotions = 0;
      bucket_only = 0;
    end else begin
      if (cfg_valid && cfg_ready) probe_cfg = cfg_data;
      if (out_valid && !out_stall) begin
        if (updates_q.size() == 0) begin
          $error("unexpected result: outcome %0d slot %0d", out_outcome, out_main_slot);
          errors++;
        end else begin
          exp_u = updates_q.pop_front();
          pending--;
          if (out_outcome !== exp_u.outcome) begin
            $error("outcome: expected %0d, got %0d", exp_u.outcome, out_outcome);
            errors++;
          end
          if (out_main_slot !== exp_u.slot) begin
            $error("main_slot: expected %0d, got %0d", exp_u.slot, out_main_slot);
            errors++;
          end
          if (out_anc_slot !== exp_u.bucket) begin
            $error("anc_slot: expected %0d, got %0d", exp_u.bucket, out_anc_slot);
            errors++;
          end
          if (out_count_after !== exp_u.count) begin
            $error("count_after: expected %0d, got %0d", exp_u.count, out_count_after);
            errors++;
          end
        end
      end
      if (in_valid && !in_stall) begin
        insert_flow(exp_u);
        if (exp_u.outcome == OUT_PROMOTE) promotions++;
        if (exp_u.outcome == OUT_ANC) bucket_only++;
        updates_q.push_back(exp_u);
        pending++;
      end
    end
  end

endmodule

### verif/tb.sv
// Testbench top: drives requests and configuration into the flow table block.
`timescale 1ns / 1ps
module tb;
  import ftip_pkg::*;

  logic        clk = 0;
  logic        rst_n = 0;
  logic        in_valid = 0;
  logic        in_stall;
  logic [31:0] in_src_addr = '0;
  logic [31:0] in_dst_addr = '0;
  logic [15:0] in_src_port = '0;
  logic [15:0] in_dst_port = '0;
  logic [7:0]  in_proto = '0;
  logic [15:0] in_increment = '0;
  logic [9:0]  in_probe_index_0 = '0;
  logic [9:0]  in_probe_index_1 = '0;
  logic [9:0]  in_probe_index_2 = '0;
  logic [9:0]  in_probe_index_3 = '0;
  logic [7:0]  in_bucket_index = '0;
  logic        out_valid;
  logic        out_stall = 0;
  logic [1:0]  out_outcome;
  logic [9:0]  out_main_slot;
  logic [7:0]  out_anc_slot;
  logic [30:0] out_count_after;
  logic        cfg_valid = 0;
  logic        cfg_ready;
  logic [2:0]  cfg_data = '0;

  int errors, pending, promotions, bucket_only;
  int stall_left, stall_next;
  bit no_idle;
  int sent;
  logic [KEY_W-1:0] flow_pool[24];

  flow_table_insert_with_promotion_top i_dut (.*);

  ftip_checker i_checker (.*);

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_left = 0;
      out_stall <= 0;
    end else begin
      if (out_valid && !out_stall) stall_next = no_idle ? 0 : $urandom_range(0, 11);
      else stall_next = (stall_left > 0) ? stall_left - 1 : 0;
      stall_left = stall_next;
      out_stall <= (stall_next != 0);
    end
  end

  task automatic send_flow(logic [KEY_W-1:0] key, logic [15:0] inc, logic [9:0] p0,
                           logic [9:0] p1, logic [9:0] p2, logic [9:0] p3, logic [7:0] b);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1;
    {in_src_addr, in_dst_addr, in_src_port, in_dst_port, in_proto} <= key;
    in_increment <= inc;
    in_probe_index_0 <= p0;
    in_probe_index_1 <= p1;
    in_probe_index_2 <= p2;
    in_probe_index_3 <= p3;
    in_bucket_index <= b;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic write_probes(logic [2:0] v);
    in_valid <= 0;
    wait (pending == 0);
    repeat (16) @(posedge clk);
    cfg_valid <= 1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  function automatic logic [9:0] pick_probe();
    return ($urandom_range(0, 99) < 85) ? 10'($urandom_range(0, 31)) : 10'($urandom);
  endfunction

  task automatic random_flow();
    logic [KEY_W-1:0] key;
    logic [15:0] inc;
    logic [7:0]  b;
    key = ($urandom_range(0, 99) < 80) ? flow_pool[$urandom_range(0, 23)]
                                       : KEY_W'({$urandom, $urandom, $urandom, $urandom});
    inc = ($urandom_range(0, 3) == 0) ? 16'($urandom) : 16'($urandom_range(0, 300));
    b = ($urandom_range(0, 99) < 80) ? 8'($urandom_range(0, 7)) : 8'($urandom);
    send_flow(key, inc, pick_probe(), pick_probe(), pick_probe(), pick_probe(), b);
  endtask

  initial begin
    logic [2:0] phases[7];
    logic [KEY_W-1:0] ones;
    phases = '{3'd1, 3'd0, 3'd7, 3'd2, 3'd3, 3'd5, 3'd4};
    ones = '1;
    sent = 0;
    no_idle = 0;
    foreach (flow_pool[i]) flow_pool[i] = KEY_W'({$urandom, $urandom, $urandom, $urandom});
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // extremes, then a claim/match chain that overflows into the bucket and promotes
    send_flow('0, 16'd0, 10'd0, 10'd0, 10'd0, 10'd0, 8'd0);
    send_flow(ones, 16'hFFFF, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 8'd255);
    send_flow(ones, 16'hFFFF, 10'd1023, 10'd1, 10'd2, 10'd3, 8'd255);
    send_flow('0, 16'd5, 10'd0, 10'd9, 10'd9, 10'd9, 8'd0);
    for (int k = 1; k <= 4; k++)
      send_flow(KEY_W'(k), 16'd100, 10'd5, 10'd6, 10'd7, 10'd8, 8'd3);
    send_flow(KEY_W'(1), 16'd20, 10'd5, 10'd6, 10'd7, 10'd8, 8'd3);
    send_flow(KEY_W'(9), 16'd50, 10'd5, 10'd6, 10'd7, 10'd8, 8'd3);
    send_flow(KEY_W'(9), 16'd60, 10'd5, 10'd6, 10'd7, 10'd8, 8'd3);
    send_flow(KEY_W'(9), 16'd1, 10'd5, 10'd6, 10'd7, 10'd8, 8'd3);
    send_flow(KEY_W'(10), 16'd0, 10'd5, 10'd6, 10'd7, 10'd8, 8'd3);
    send_flow(KEY_W'(11), 16'd7, 10'd6, 10'd7, 10'd8, 10'd5, 8'd3);
    send_flow(KEY_W'(12), 16'hFFFF, 10'd8, 10'd7, 10'd6, 10'd5, 8'd4);

    foreach (phases[p]) begin
      write_probes(phases[p]);
      no_idle = (p == 3);
      repeat (178) random_flow();
    end
    in_valid <= 0;

    wait (pending == 0);
    repeat (40) @(posedge clk);
    $display("Sent %0d requests over probe settings 1,0,7,2,3,5,4 with random idling;",
             sent);
    $display("%0d bucket-only updates and %0d promotions seen.", bucket_only, promotions);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  initial begin
    #20_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
